FILE: design/queue_with_middle_insert_macros.svh
// assertion macros for the middle-insert queue
// included by the rtl files that carry concurrent checks
`ifndef QUEUE_WITH_MIDDLE_INSERT_MACROS_SVH
`define QUEUE_WITH_MIDDLE_INSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, off while reset is asserted
`define QWMI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("qwmi check failed");
// checked property, active at every edge
`define QWMI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("qwmi check failed");
`else
`define QWMI_ASSERT(lbl, clk, rstn, prop)
`define QWMI_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: design/qwmi_pkg.sv
// shared types and constants of the middle-insert queue
// no dependencies
`default_nettype none
package qwmi_pkg;

  localparam int CAPACITY    = 1024;
  localparam int FRONT_DEPTH = (CAPACITY + 1) / 2;
  localparam int BACK_DEPTH  = CAPACITY / 2;
  localparam int FRONT_AW    = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int BACK_AW     = (BACK_DEPTH > 1) ? $clog2(BACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(FRONT_DEPTH + 1);
  localparam int TOTAL_W     = $clog2(CAPACITY + 1);

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // command codes, a set high bit means pop
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
  localparam int               CMD_POP_BIT = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_OK = 2'd0,
    ST_POP_OK  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // write plan for the commit cycle of one command
  typedef struct packed {
    logic                front_we;
    logic                front_from_back;
    logic [FRONT_AW-1:0] front_waddr;
    logic                back_we;
    logic [BACK_AW-1:0]  back_waddr;
    status_e             status;
  } plan_t;

endpackage
`default_nettype wire

FILE: design/qwmi_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module qwmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/qwmi_ctrl.sv
// head pointers and counts of both halves, write plan per command
// depends on qwmi_pkg and the assertion macro header
`default_nettype none
`include "queue_with_middle_insert_macros.svh"
module qwmi_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            commit_i,
  input  wire logic [qwmi_pkg::CMD_W-1:0]      cmd_i,
  output logic      [qwmi_pkg::FRONT_AW-1:0]   front_raddr_o,
  output logic      [qwmi_pkg::BACK_AW-1:0]    back_raddr_o,
  output qwmi_pkg::plan_t                      plan_o
);

  localparam int FAW = qwmi_pkg::FRONT_AW;
  localparam int BAW = qwmi_pkg::BACK_AW;
  localparam int CW  = qwmi_pkg::CNT_W;
  localparam int TW  = qwmi_pkg::TOTAL_W;

  logic [FAW-1:0] front_head_q, front_head_d;
  logic [BAW-1:0] back_head_q, back_head_d;
  logic [CW-1:0]  front_count_q, front_count_d;
  logic [CW-1:0]  back_count_q, back_count_d;

  logic [TW-1:0]  total;
  logic           balanced;
  logic [FAW:0]   front_tail_sum;
  logic [FAW-1:0] front_tail;
  logic [FAW-1:0] front_head_inc;
  logic [BAW:0]   back_tail_sum;
  logic [BAW-1:0] back_tail;
  logic [BAW-1:0] back_head_inc;
  logic [BAW-1:0] back_head_dec;
  qwmi_pkg::plan_t plan;

  assign total    = TW'(front_count_q) + TW'(back_count_q);
  assign balanced = (front_count_q == back_count_q);

  // ring index arithmetic, one compare and subtract each
  assign front_tail_sum = {1'b0, front_head_q} + (FAW + 1)'(front_count_q);
  assign front_tail = (front_tail_sum >= (FAW + 1)'(qwmi_pkg::FRONT_DEPTH)) ?
      FAW'(front_tail_sum - (FAW + 1)'(qwmi_pkg::FRONT_DEPTH)) : FAW'(front_tail_sum);
  assign front_head_inc = (front_head_q == FAW'(qwmi_pkg::FRONT_DEPTH - 1)) ?
      '0 : front_head_q + 1'b1;

  assign back_tail_sum = {1'b0, back_head_q} + (BAW + 1)'(back_count_q);
  assign back_tail = (back_tail_sum >= (BAW + 1)'(qwmi_pkg::BACK_DEPTH)) ?
      BAW'(back_tail_sum - (BAW + 1)'(qwmi_pkg::BACK_DEPTH)) : BAW'(back_tail_sum);
  assign back_head_inc = (back_head_q == BAW'(qwmi_pkg::BACK_DEPTH - 1)) ?
      '0 : back_head_q + 1'b1;
  assign back_head_dec = (back_head_q == '0) ?
      BAW'(qwmi_pkg::BACK_DEPTH - 1) : back_head_q - 1'b1;

  always_comb begin
    front_head_d  = front_head_q;
    back_head_d   = back_head_q;
    front_count_d = front_count_q;
    back_count_d  = back_count_q;
    plan.front_we        = 1'b0;
    plan.front_from_back = 1'b0;
    plan.front_waddr     = front_tail;
    plan.back_we         = 1'b0;
    plan.back_waddr      = back_tail;
    plan.status          = qwmi_pkg::ST_PUSH_OK;
    priority if (cmd_i[qwmi_pkg::CMD_POP_BIT]) begin
      if (total == '0) begin
        plan.status = qwmi_pkg::ST_EMPTY;
      end else begin
        plan.status  = qwmi_pkg::ST_POP_OK;
        front_head_d = front_head_inc;
        if (balanced) begin
          // front would fall short: pull the back head across
          plan.front_we        = 1'b1;
          plan.front_from_back = 1'b1;
          back_head_d          = back_head_inc;
          back_count_d         = back_count_q - 1'b1;
        end else begin
          front_count_d = front_count_q - 1'b1;
        end
      end
    end else if (total >= TW'(qwmi_pkg::CAPACITY)) begin
      plan.status = qwmi_pkg::ST_FULL;
    end else if (cmd_i == qwmi_pkg::CMD_APPEND) begin
      if (balanced) begin
        plan.front_we = 1'b1;
        front_count_d = front_count_q + 1'b1;
        if (back_count_q != '0) begin
          // back head moves to front, new word goes to back tail
          plan.front_from_back = 1'b1;
          plan.back_we         = 1'b1;
          back_head_d          = back_head_inc;
        end
      end else begin
        plan.back_we = 1'b1;
        back_count_d = back_count_q + 1'b1;
      end
    end else begin
      if (balanced) begin
        plan.front_we = 1'b1;
        front_count_d = front_count_q + 1'b1;
      end else begin
        plan.back_we    = 1'b1;
        plan.back_waddr = back_head_dec;
        back_head_d     = back_head_dec;
        back_count_d    = back_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_head_q  <= '0;
      back_head_q   <= '0;
      front_count_q <= '0;
      back_count_q  <= '0;
    end else if (commit_i) begin
      front_head_q  <= front_head_d;
      back_head_q   <= back_head_d;
      front_count_q <= front_count_d;
      back_count_q  <= back_count_d;
    end
  end

  assign front_raddr_o = front_head_q;
  assign back_raddr_o  = back_head_q;
  assign plan_o        = plan;

  `QWMI_ASSERT(a_split_kept, clk_i, rst_ni,
      (front_count_q == back_count_q) || (front_count_q == back_count_q + 1'b1))
  `QWMI_ASSERT(a_total_bound, clk_i, rst_ni, total <= TW'(qwmi_pkg::CAPACITY))
  `QWMI_ASSERT(a_hold_idle, clk_i, rst_ni,
      !commit_i |=> $stable(front_count_q) && $stable(back_count_q))

endmodule
`default_nettype wire

FILE: design/queue_with_middle_insert.sv
// top level of the middle-insert queue: handshakes, result register, two rings
// depends on qwmi_pkg, qwmi_ctrl, qwmi_ram and the assertion macro header
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | into      | in_valid_i/in_ready_o | cmd_i, item_value_i
//   out     | out of    | out_valid_o/out_ready_i | status_o, popped_value_o
//
// each command runs in two steps: the accept edge issues the reads of both ring
// heads, the commit edge writes the rings, updates pointers and loads the result
// a new word is taken while the previous result still waits in the out register
// the commit cycle stalls while the out register is full and not being taken
// reset clears pointers, counts and handshake state; ring contents stay unknown
`default_nettype none
`include "queue_with_middle_insert_macros.svh"
module queue_with_middle_insert (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic        [qwmi_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic signed [qwmi_pkg::DATA_W-1:0] item_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic        [qwmi_pkg::STATUS_W-1:0]    status_o,
  output logic signed [qwmi_pkg::DATA_W-1:0]      popped_value_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept;
  logic commit;

  logic [qwmi_pkg::CMD_W-1:0]  cmd_q;
  logic [qwmi_pkg::DATA_W-1:0] item_q;

  logic                                out_valid_q;
  logic [qwmi_pkg::STATUS_W-1:0]       status_q;
  logic [qwmi_pkg::DATA_W-1:0]         popped_q;

  logic [qwmi_pkg::FRONT_AW-1:0] front_raddr;
  logic [qwmi_pkg::BACK_AW-1:0]  back_raddr;
  logic [qwmi_pkg::DATA_W-1:0]   front_rdata;
  logic [qwmi_pkg::DATA_W-1:0]   back_rdata;
  logic [qwmi_pkg::DATA_W-1:0]   front_wdata;
  qwmi_pkg::plan_t               plan;

  // one command in flight; idle state takes the next word
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command word and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      item_q <= item_value_i;
    end
    if (commit) begin
      status_q <= plan.status;
      popped_q <= (plan.status == qwmi_pkg::ST_POP_OK) ? front_rdata : '0;
    end
  end

  qwmi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (commit),
    .cmd_i         (cmd_q),
    .front_raddr_o (front_raddr),
    .back_raddr_o  (back_raddr),
    .plan_o        (plan)
  );

  // front tail takes either the new word or the word leaving the back head
  assign front_wdata = plan.front_from_back ? back_rdata : item_q;

  qwmi_ram #(
    .WIDTH (qwmi_pkg::DATA_W),
    .DEPTH (qwmi_pkg::FRONT_DEPTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (commit && plan.front_we),
    .waddr_i (plan.front_waddr),
    .wdata_i (front_wdata),
    .re_i    (accept),
    .raddr_i (front_raddr),
    .rdata_o (front_rdata)
  );

  qwmi_ram #(
    .WIDTH (qwmi_pkg::DATA_W),
    .DEPTH (qwmi_pkg::BACK_DEPTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (commit && plan.back_we),
    .waddr_i (plan.back_waddr),
    .wdata_i (item_q),
    .re_i    (accept),
    .raddr_i (back_raddr),
    .rdata_o (back_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;

  `QWMI_ASSERT(a_accept_then_exec, clk_i, rst_ni, accept |=> !in_ready_o)
  `QWMI_ASSERT(a_commit_shows, clk_i, rst_ni, commit |=> out_valid_o)
  `QWMI_ASSERT(a_popped_zero, clk_i, rst_ni,
      out_valid_o && (status_o != qwmi_pkg::ST_POP_OK) |-> popped_value_o == '0)

endmodule
`default_nettype wire
